// ===== hw/rtl/scpa_pkg.sv =====
// scpa_pkg: constants, page descriptor type and size class helpers for the
// size class page allocator. Depends on nothing.
`default_nettype none

package scpa_pkg;

  localparam int NUM_PAGES       = 16;
  localparam int PAGE_BYTES      = 1024;
  localparam int MIN_CLASS_BYTES = 16;
  localparam int HEADER_BYTES    = 5;

  localparam int SIZE_W      = 15;
  localparam int ADDR_W      = 32;
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int RUN_W       = PAGE_W + 1;
  localparam int PAGE_LOG    = $clog2(PAGE_BYTES);
  localparam int MIN_LOG     = $clog2(MIN_CLASS_BYTES);
  localparam int CLASS_STEPS = PAGE_LOG - MIN_LOG;
  localparam int CLS_W       = 4;
  localparam int OFF_W       = $clog2(PAGE_BYTES + 1);
  localparam int FREE_W      = $clog2(PAGE_BYTES / MIN_CLASS_BYTES + 1);

  localparam logic [ADDR_W-1:0] POOL_BYTES = ADDR_W'(NUM_PAGES * PAGE_BYTES);
  localparam logic [PAGE_W-1:0] LAST_PAGE  = PAGE_W'(NUM_PAGES - 1);

  typedef struct packed {
    logic              used;
    logic [CLS_W-1:0]  class_log;
    logic [OFF_W-1:0]  next_off;
    logic [FREE_W-1:0] free_blocks;
  } page_desc_t;

  // doubling count of the least class above size plus header, capped at a page
  function automatic logic [CLS_W-1:0] class_log_of(input logic [SIZE_W-1:0] size);
    logic [OFF_W:0]   need;
    logic [OFF_W:0]   cls;
    logic [CLS_W-1:0] k;
    need = (OFF_W+1)'(size) + (OFF_W+1)'(HEADER_BYTES);
    cls  = (OFF_W+1)'(MIN_CLASS_BYTES);
    k    = '0;
    for (int j = 0; j < CLASS_STEPS; j++) begin
      if (cls <= need && cls < (OFF_W+1)'(PAGE_BYTES)) begin
        cls = cls << 1;
        k   = k + 1'b1;
      end
    end
    return k;
  endfunction

  function automatic logic [OFF_W-1:0] class_bytes(input logic [CLS_W-1:0] k);
    return OFF_W'(MIN_CLASS_BYTES) << k;
  endfunction

  function automatic logic [FREE_W-1:0] blocks_left(input logic [CLS_W-1:0] k);
    return FREE_W'((PAGE_BYTES >> (MIN_LOG + int'(k))) - 1);
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [PAGE_W-1:0] page,
                                                  input logic [OFF_W-1:0]  off);
    return base + (ADDR_W'(page) << PAGE_LOG) + ADDR_W'(off);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/size_class_page_allocator.sv =====
// size_class_page_allocator: top level, page descriptor memory and the scan
// and write-back sequencer. Depends on scpa_pkg.
`default_nettype none

// Serves one allocation request at a time from a pool of 16 pages of 1024
// bytes. Page descriptors live in a single-port-read, single-port-write
// memory with a registered read port, walked one entry per cycle. A small
// request scans for a partly used page of its class and, failing that, scans
// again for a free page, then writes back the page taken and returns the
// result. A medium or large request needs one scan plus a write-back of each
// page taken (up to 16 for a large run). A refused request skips the scan
// and goes straight to the result. Reset leaves every page free at once
// through per-entry valid bits; no clearing pass is needed.
// pool_base may be written only while no request is in flight.
module size_class_page_allocator (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [scpa_pkg::SIZE_W-1:0]  in_request_size,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [scpa_pkg::ADDR_W-1:0]  out_grant_address,
  output logic                         out_granted,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [scpa_pkg::ADDR_W-1:0]  cfg_pool_base
);
  import scpa_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE, ST_DONE} state_t;
  typedef enum logic [1:0] {PS_CLASS, PS_FREE_SMALL, PS_WHOLE, PS_RUN} pass_t;

  page_desc_t mem [NUM_PAGES];
  page_desc_t mem_q_r;

  state_t             state_r;
  pass_t              pass_r;
  logic [ADDR_W-1:0]  pool_base_r;
  logic [NUM_PAGES-1:0] entry_vld_r;
  logic [PAGE_W-1:0]  rd_addr_r;
  logic               issued_all_r;
  logic               q_vld_r;
  logic               q_ok_r;
  logic [PAGE_W-1:0]  q_idx_r;
  logic [CLS_W-1:0]   k_r;
  logic [OFF_W-1:0]   cls_r;
  logic [RUN_W-1:0]   n_r;
  logic [RUN_W-1:0]   run_r;
  logic [PAGE_W-1:0]  start_r;
  logic [PAGE_W-1:0]  wr_idx_r;
  logic [RUN_W-1:0]   wr_left_r;
  page_desc_t         wr_data_r;
  logic [ADDR_W-1:0]  addr_r;
  logic               granted_r;
  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               out_granted_r;

  page_desc_t         ent;
  page_desc_t         new_ent;
  logic               hit;
  logic               stop;
  logic               rd_en;
  logic               wr_en;
  logic [PAGE_W-1:0]  run_start;
  logic [PAGE_W-1:0]  page_sel;
  logic [OFF_W-1:0]   off_sel;
  logic [ADDR_W-1:0]  size32;
  logic               req_refuse;
  logic               req_small;
  logic               req_medium;
  logic [ADDR_W-1:0]  n_full;

  assign in_stall          = (state_r != ST_IDLE);
  assign cfg_ready         = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_grant_address = out_addr_r;
  assign out_granted       = out_granted_r;

  always_comb begin
    size32     = ADDR_W'(in_request_size);
    req_refuse = (size32 == '0) || (size32 > POOL_BYTES);
    req_small  = (size32 <= ADDR_W'(PAGE_BYTES / 2));
    req_medium = (size32 + ADDR_W'(HEADER_BYTES) < ADDR_W'(PAGE_BYTES));
    n_full     = (size32 + ADDR_W'(PAGE_BYTES - 1)) >> PAGE_LOG;
  end

  always_comb begin
    ent       = q_ok_r ? mem_q_r : '0;
    run_start = (run_r == '0) ? q_idx_r : start_r;
    page_sel  = (pass_r == PS_RUN) ? run_start : q_idx_r;
    off_sel   = (pass_r == PS_CLASS) ? ent.next_off : '0;
    new_ent   = '{used: 1'b1, class_log: '0, next_off: OFF_W'(PAGE_BYTES), free_blocks: '0};
    hit       = 1'b0;
    case (pass_r)
      PS_CLASS: begin
        hit = ent.used && (ent.class_log == k_r) && (ent.free_blocks != '0);
        new_ent.class_log   = ent.class_log;
        new_ent.next_off    = ent.next_off + cls_r;
        new_ent.free_blocks = ent.free_blocks - 1'b1;
      end
      PS_FREE_SMALL: begin
        hit = !ent.used;
        new_ent.class_log   = k_r;
        new_ent.next_off    = cls_r;
        new_ent.free_blocks = blocks_left(k_r);
      end
      PS_WHOLE: hit = !ent.used;
      PS_RUN:   hit = !ent.used && (run_r + 1'b1 == n_r);
      default:  hit = 1'b0;
    endcase
    stop  = q_vld_r && (hit || q_idx_r == LAST_PAGE);
    rd_en = (state_r == ST_SCAN) && !issued_all_r && !stop;
    wr_en = (state_r == ST_WRITE);
  end

  // descriptor memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx_r] <= wr_data_r;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pass_r        <= PS_CLASS;
      pool_base_r   <= '0;
      entry_vld_r   <= '0;
      rd_addr_r     <= '0;
      issued_all_r  <= 1'b0;
      q_vld_r       <= 1'b0;
      q_ok_r        <= 1'b0;
      run_r         <= '0;
      wr_left_r     <= '0;
      out_valid_r   <= 1'b0;
      out_granted_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        pool_base_r <= cfg_pool_base;
      end
      q_vld_r <= rd_en;
      if (rd_en) begin
        q_idx_r   <= rd_addr_r;
        q_ok_r    <= entry_vld_r[rd_addr_r];
        rd_addr_r <= rd_addr_r + 1'b1;
        if (rd_addr_r == LAST_PAGE) begin
          issued_all_r <= 1'b1;
        end
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            k_r          <= class_log_of(in_request_size);
            cls_r        <= class_bytes(class_log_of(in_request_size));
            n_r          <= RUN_W'(n_full);
            run_r        <= '0;
            rd_addr_r    <= '0;
            issued_all_r <= 1'b0;
            if (req_refuse) begin
              granted_r <= 1'b0;
              addr_r    <= '0;
              state_r   <= ST_DONE;
            end else begin
              state_r <= ST_SCAN;
              if (req_small) begin
                pass_r <= PS_CLASS;
              end else if (req_medium) begin
                pass_r <= PS_WHOLE;
              end else begin
                pass_r <= PS_RUN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (q_vld_r) begin
            if (pass_r == PS_RUN) begin
              run_r <= ent.used ? '0 : run_r + 1'b1;
              if (!ent.used && run_r == '0) begin
                start_r <= q_idx_r;
              end
            end
            if (hit) begin
              addr_r    <= make_addr(pool_base_r, page_sel, off_sel);
              wr_idx_r  <= page_sel;
              wr_data_r <= new_ent;
              wr_left_r <= (pass_r == PS_RUN) ? n_r : RUN_W'(1);
              state_r   <= ST_WRITE;
            end else if (q_idx_r == LAST_PAGE) begin
              if (pass_r == PS_CLASS) begin
                pass_r       <= PS_FREE_SMALL;
                rd_addr_r    <= '0;
                issued_all_r <= 1'b0;
              end else begin
                granted_r <= 1'b0;
                addr_r    <= '0;
                state_r   <= ST_DONE;
              end
            end
          end
        end
        ST_WRITE: begin
          entry_vld_r[wr_idx_r] <= 1'b1;
          wr_idx_r              <= wr_idx_r + 1'b1;
          wr_left_r             <= wr_left_r - 1'b1;
          if (wr_left_r == RUN_W'(1)) begin
            granted_r <= 1'b1;
            state_r   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_addr_r    <= addr_r;
            out_granted_r <= granted_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_grant_address == '0)
    else $error("refused beat carries a nonzero address");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE)
    else $error("accepted request left the sequencer idle");

  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |-> wr_left_r != '0)
    else $error("write-back with no pages left to write");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld_r |-> $past(rd_en))
    else $error("descriptor data marked valid without a read");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en && !q_vld_r)
    else $error("descriptor write overlaps a scan read");

endmodule

`default_nettype wire
